// ----- src/spmd_pkg.sv -----
// ----------------------------------------------------------------------------
// spmd_pkg
// Widths, step types and step functions shared by the segment pair
// minimum distance pipeline: one bit of square root or of quotient per step.
// ----------------------------------------------------------------------------
package spmd_pkg;

   localparam int CoordW  = 32;            // input coordinate, signed Q16.16
   localparam int RadiusW = 31;            // inset radius, unsigned Q15.16
   localparam int EndW    = 34;            // inset end point, signed
   localparam int DiffW   = 35;            // difference of two inset ends
   localparam int ProdW   = 2 * DiffW;     // one product of differences
   localparam int SumW    = ProdW + 2;     // sum of two products
   localparam int DistW   = 33;            // result distance, unsigned Q17.16

   localparam int RootW   = 52;            // root bits, one per sqrt step
   localparam int RadW    = 2 * RootW;     // radicand bits
   localparam int SqRemW  = RootW + 2;     // partial remainder of the sqrt
   localparam int NumW    = 87;            // dividend bits
   localparam int DenW    = RootW;         // divisor bits
   localparam int QuoW    = DistW;         // quotient bits, one per divide step
   localparam int HiW     = NumW - QuoW;   // dividend bits above the quotient

   localparam logic [DistW-1:0] DistMax = '1;
   localparam logic [DenW-1:0]  UnitDen = DenW'(65536);   // 1.0 in Q16.16

   typedef struct packed {
      logic [SqRemW-1:0] rem;
      logic [RootW-1:0]  root;
      logic [RadW-1:0]   rad;
   } sqrt_type;

   typedef struct packed {
      logic [DenW-1:0] rem;
      logic [DenW-1:0] den;
      logic [QuoW-1:0] nlo;
      logic [QuoW-1:0] quo;
      logic            sat;
   } div_type;

   function automatic sqrt_type sqrt_init(input logic [RadW-1:0] rad);
      sqrt_type s;
      s.rem  = '0;
      s.root = '0;
      s.rad  = rad;
      return s;
   endfunction

   // restoring square root, two radicand bits in, one root bit out
   function automatic sqrt_type sqrt_step(input sqrt_type s);
      sqrt_type          r;
      logic [SqRemW+1:0] cur;
      logic [SqRemW+1:0] trial;
      cur   = {s.rem, s.rad[RadW-1 -: 2]};
      trial = {2'b00, s.root, 2'b01};
      r.rad = {s.rad[RadW-3:0], 2'b00};
      if (cur >= trial) begin
         r.rem  = SqRemW'(cur - trial);
         r.root = {s.root[RootW-2:0], 1'b1};
      end else begin
         r.rem  = SqRemW'(cur);
         r.root = {s.root[RootW-2:0], 1'b0};
      end
      return r;
   endfunction

   // quotient saturates when the upper dividend bits reach the divisor
   function automatic div_type div_init(input logic [NumW-1:0] num,
                                        input logic [DenW-1:0] den);
      div_type        d;
      logic [HiW-1:0] hi;
      hi    = num[NumW-1:QuoW];
      d.sat = (hi >= HiW'(den));
      d.rem = hi[DenW-1:0];
      d.den = den;
      d.nlo = num[QuoW-1:0];
      d.quo = '0;
      return d;
   endfunction

   function automatic div_type div_step(input div_type s);
      div_type       d;
      logic [DenW:0] t;
      t     = {s.rem, s.nlo[QuoW-1]};
      d.den = s.den;
      d.sat = s.sat;
      d.nlo = {s.nlo[QuoW-2:0], 1'b0};
      if (t >= {1'b0, s.den}) begin
         d.rem = DenW'(t - {1'b0, s.den});
         d.quo = {s.quo[QuoW-2:0], 1'b1};
      end else begin
         d.rem = t[DenW-1:0];
         d.quo = {s.quo[QuoW-2:0], 1'b0};
      end
      return d;
   endfunction

   function automatic logic [DistW-1:0] div_result(input div_type s);
      return s.sat ? DistMax : s.quo;
   endfunction

endpackage

// ----- src/segment_pair_min_distance_top.sv -----
// ----------------------------------------------------------------------------
// segment_pair_min_distance_top
// Least distance between two 2D segments after each is inset at both ends.
// ----------------------------------------------------------------------------
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_ready  | two segments, inset radius
//   rsp     | out | rsp_valid/rsp_ready  | rsp_min_distance
//
// One item per cycle while a stalled output does not hold the pipeline. Inset
// part and distance part each run one root bit and one quotient bit per stage.
// Reset clears all valid bits; payload registers are not reset.
// A stalled output holds the whole pipeline only once its last stage is
// full; bubbles ahead of it keep filling.
// ----------------------------------------------------------------------------
module segment_pair_min_distance_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [spmd_pkg::CoordW-1:0]   req_first_start_x,
   input  logic signed [spmd_pkg::CoordW-1:0]   req_first_start_y,
   input  logic signed [spmd_pkg::CoordW-1:0]   req_first_end_x,
   input  logic signed [spmd_pkg::CoordW-1:0]   req_first_end_y,
   input  logic signed [spmd_pkg::CoordW-1:0]   req_second_start_x,
   input  logic signed [spmd_pkg::CoordW-1:0]   req_second_start_y,
   input  logic signed [spmd_pkg::CoordW-1:0]   req_second_end_x,
   input  logic signed [spmd_pkg::CoordW-1:0]   req_second_end_y,
   input  logic        [spmd_pkg::RadiusW-1:0]  req_inset_radius,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic        [spmd_pkg::DistW-1:0]    rsp_min_distance
);

   localparam int CoordW  = spmd_pkg::CoordW;
   localparam int RadiusW = spmd_pkg::RadiusW;
   localparam int EndW    = spmd_pkg::EndW;
   localparam int DistW   = spmd_pkg::DistW;
   localparam int RootW   = spmd_pkg::RootW;
   localparam int QuoW    = spmd_pkg::QuoW;
   localparam int NumW    = spmd_pkg::NumW;
   localparam int MagW    = CoordW + 1;
   localparam int SqW     = 2 * MagW;
   localparam int MrW     = MagW + RadiusW;
   localparam int Lat     = RootW + QuoW + 5;

   typedef struct packed {
      logic signed [CoordW-1:0] sx;
      logic signed [CoordW-1:0] sy;
      logic signed [CoordW-1:0] ex;
      logic signed [CoordW-1:0] ey;
      logic                     neg_x;
      logic                     neg_y;
      logic                     zero;
      logic [RadiusW-1:0]       r;
   } ends_carry_type;

   typedef struct packed {
      ends_carry_type  e;
      logic [NumW-1:0] nx;
      logic [NumW-1:0] ny;
   } inset_carry_type;

   logic en, out_load;
   logic [Lat-1:0] vld_ff;

   logic signed [CoordW-1:0] in_sx [2], in_sy [2], in_ex [2], in_ey [2];

   ends_carry_type     a_ff [2];
   logic [MagW-1:0]    amx_ff [2], amy_ff [2];
   ends_carry_type     b_ff [2];
   logic [SqW-1:0]     sqx_ff [2], sqy_ff [2];
   logic [MrW-1:0]     nx_ff [2], ny_ff [2];

   spmd_pkg::sqrt_type sq_ff [2][RootW+1];
   inset_carry_type    icar_ff [2][RootW+1];
   spmd_pkg::div_type  dvx_ff [2][QuoW+1];
   spmd_pkg::div_type  dvy_ff [2][QuoW+1];
   ends_carry_type     dcar_ff [2][QuoW+1];

   logic signed [EndW-1:0] e_sx_ff [2], e_sy_ff [2], e_ex_ff [2], e_ey_ff [2];

   logic [3:0]       dist_v;
   logic [DistW-1:0] dist_d [4];

   logic [DistW-1:0] m_ff [2];
   logic             m_v_ff;
   logic             rsp_valid_ff;
   logic [DistW-1:0] rsp_dist_ff;

   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign en        = !m_v_ff || out_load;
   assign req_ready = en;

   assign in_sx[0] = req_first_start_x;
   assign in_sy[0] = req_first_start_y;
   assign in_ex[0] = req_first_end_x;
   assign in_ey[0] = req_first_end_y;
   assign in_sx[1] = req_second_start_x;
   assign in_sy[1] = req_second_start_y;
   assign in_ex[1] = req_second_end_x;
   assign in_ey[1] = req_second_end_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[Lat-2:0], req_valid};
      end
   end

   for (genvar k = 0; k < 2; k++) begin : g_seg
      logic signed [MagW-1:0] dx_in, dy_in;
      logic [SqW-1:0]         s_in;
      ends_carry_type         be_in;
      spmd_pkg::div_type      dx_last, dy_last;
      logic [DistW-1:0]       mx_in, my_in;
      logic signed [EndW-1:0] ox_in, oy_in;

      assign dx_in = MagW'(in_ex[k]) - MagW'(in_sx[k]);
      assign dy_in = MagW'(in_ey[k]) - MagW'(in_sy[k]);
      assign s_in  = sqx_ff[k] + sqy_ff[k];

      always_comb begin
         be_in      = b_ff[k];
         be_in.zero = (s_in == '0);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            a_ff[k].sx    <= in_sx[k];
            a_ff[k].sy    <= in_sy[k];
            a_ff[k].ex    <= in_ex[k];
            a_ff[k].ey    <= in_ey[k];
            a_ff[k].neg_x <= dx_in[MagW-1];
            a_ff[k].neg_y <= dy_in[MagW-1];
            a_ff[k].zero  <= 1'b0;
            a_ff[k].r     <= req_inset_radius;
            amx_ff[k]     <= dx_in[MagW-1] ? MagW'(-dx_in) : MagW'(dx_in);
            amy_ff[k]     <= dy_in[MagW-1] ? MagW'(-dy_in) : MagW'(dy_in);

            b_ff[k]   <= a_ff[k];
            sqx_ff[k] <= amx_ff[k] * amx_ff[k];
            sqy_ff[k] <= amy_ff[k] * amy_ff[k];
            nx_ff[k]  <= amx_ff[k] * a_ff[k].r;
            ny_ff[k]  <= amy_ff[k] * a_ff[k].r;

            // length in Q.32 from sqrt(S * 2^32)
            sq_ff[k][0]        <= spmd_pkg::sqrt_init(spmd_pkg::RadW'({s_in, 32'b0}));
            icar_ff[k][0].e    <= be_in;
            icar_ff[k][0].nx   <= NumW'({nx_ff[k], 16'b0});
            icar_ff[k][0].ny   <= NumW'({ny_ff[k], 16'b0});
         end
      end

      for (genvar i = 1; i <= RootW; i++) begin : g_sqrt
         always_ff @(posedge clock) begin
            if (en) begin
               sq_ff[k][i]   <= spmd_pkg::sqrt_step(sq_ff[k][i-1]);
               icar_ff[k][i] <= icar_ff[k][i-1];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dvx_ff[k][0]  <= spmd_pkg::div_init(icar_ff[k][RootW].nx, sq_ff[k][RootW].root);
            dvy_ff[k][0]  <= spmd_pkg::div_init(icar_ff[k][RootW].ny, sq_ff[k][RootW].root);
            dcar_ff[k][0] <= icar_ff[k][RootW].e;
         end
      end

      for (genvar i = 1; i <= QuoW; i++) begin : g_div
         always_ff @(posedge clock) begin
            if (en) begin
               dvx_ff[k][i]  <= spmd_pkg::div_step(dvx_ff[k][i-1]);
               dvy_ff[k][i]  <= spmd_pkg::div_step(dvy_ff[k][i-1]);
               dcar_ff[k][i] <= dcar_ff[k][i-1];
            end
         end
      end

      assign dx_last = dvx_ff[k][QuoW];
      assign dy_last = dvy_ff[k][QuoW];
      assign mx_in   = spmd_pkg::div_result(dx_last);
      assign my_in   = spmd_pkg::div_result(dy_last);

      // zero-length segment: start moves along +x, end along -x
      always_comb begin
         if (dcar_ff[k][QuoW].zero) begin
            ox_in = EndW'(dcar_ff[k][QuoW].r);
            oy_in = '0;
         end else begin
            ox_in = dcar_ff[k][QuoW].neg_x ? -EndW'(mx_in) : EndW'(mx_in);
            oy_in = dcar_ff[k][QuoW].neg_y ? -EndW'(my_in) : EndW'(my_in);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            e_sx_ff[k] <= EndW'(dcar_ff[k][QuoW].sx) + ox_in;
            e_sy_ff[k] <= EndW'(dcar_ff[k][QuoW].sy) + oy_in;
            e_ex_ff[k] <= EndW'(dcar_ff[k][QuoW].ex) - ox_in;
            e_ey_ff[k] <= EndW'(dcar_ff[k][QuoW].ey) - oy_in;
         end
      end
   end

   // lanes: each inset end of one segment against the other inset segment
   for (genvar j = 0; j < 4; j++) begin : g_lane
      localparam int Ps = j / 2;
      localparam int Ts = 1 - Ps;
      spmd_dist u_dist (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (vld_ff[Lat-1]),
         .px        ((j % 2 == 0) ? e_sx_ff[Ps] : e_ex_ff[Ps]),
         .py        ((j % 2 == 0) ? e_sy_ff[Ps] : e_ey_ff[Ps]),
         .ax        (e_sx_ff[Ts]),
         .ay        (e_sy_ff[Ts]),
         .bx        (e_ex_ff[Ts]),
         .by        (e_ey_ff[Ts]),
         .out_valid (dist_v[j]),
         .distance  (dist_d[j])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else if (en) begin
         m_v_ff <= &dist_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0] <= (dist_d[1] < dist_d[0]) ? dist_d[1] : dist_d[0];
         m_ff[1] <= (dist_d[3] < dist_d[2]) ? dist_d[3] : dist_d[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= m_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_dist_ff <= (m_ff[1] < m_ff[0]) ? m_ff[1] : m_ff[0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_min_distance = rsp_dist_ff;

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (m_v_ff && rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while the last stage is blocked");

   a_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      (dist_v == 4'b0000) || (dist_v == 4'b1111))
      else $error("distance lanes out of step");

   a_result_from_pipe: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid)) |-> $past(m_v_ff))
      else $error("result shown without a finished item");

endmodule

// ----- src/spmd_dist.sv -----
// ----------------------------------------------------------------------------
// spmd_dist
// Pipelined distance from a point to a segment: angle tests, then one shared
// square root and one divide, each with one bit per stage.
// ----------------------------------------------------------------------------
module spmd_dist (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic signed [spmd_pkg::EndW-1:0]   px,
   input  logic signed [spmd_pkg::EndW-1:0]   py,
   input  logic signed [spmd_pkg::EndW-1:0]   ax,
   input  logic signed [spmd_pkg::EndW-1:0]   ay,
   input  logic signed [spmd_pkg::EndW-1:0]   bx,
   input  logic signed [spmd_pkg::EndW-1:0]   by,
   output logic                               out_valid,
   output logic        [spmd_pkg::DistW-1:0]  distance
);

   localparam int RootW = spmd_pkg::RootW;
   localparam int QuoW  = spmd_pkg::QuoW;
   localparam int Lat   = RootW + QuoW + 5;
   localparam int DiffW = spmd_pkg::DiffW;
   localparam int ProdW = spmd_pkg::ProdW;
   localparam int SumW  = spmd_pkg::SumW;

   typedef struct packed {
      logic            perp;
      logic [SumW-1:0] cr;
   } dist_carry_type;

   logic [Lat-1:0] vld_ff;

   // segment direction s = b - a, offsets w = p - b and v = p - a
   logic signed [DiffW-1:0] sx_ff, sy_ff, wx_ff, wy_ff, vx_ff, vy_ff;
   logic signed [ProdW-1:0] swx_ff, swy_ff, svx_ff, svy_ff, c1_ff, c2_ff;
   logic signed [ProdW-1:0] wwx_ff, wwy_ff, vvx_ff, vvy_ff, ssx_ff, ssy_ff;
   logic signed [SumW-1:0]  dsw_ff, dsv_ff, cross_ff, eb_ff, ea_ff, nn_ff;

   logic signed [SumW-1:0]  sel_in;
   logic        [SumW-1:0]  cr_in;
   logic                    perp_in;

   spmd_pkg::sqrt_type sq_ff [RootW+1];
   dist_carry_type     car_ff [RootW+1];
   spmd_pkg::div_type  dv_ff [QuoW+1];

   logic [spmd_pkg::NumW-1:0] num_in;
   logic [spmd_pkg::DenW-1:0] den_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[Lat-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sx_ff <= DiffW'(bx) - DiffW'(ax);
         sy_ff <= DiffW'(by) - DiffW'(ay);
         wx_ff <= DiffW'(px) - DiffW'(bx);
         wy_ff <= DiffW'(py) - DiffW'(by);
         vx_ff <= DiffW'(px) - DiffW'(ax);
         vy_ff <= DiffW'(py) - DiffW'(ay);

         swx_ff <= sx_ff * wx_ff;
         swy_ff <= sy_ff * wy_ff;
         svx_ff <= sx_ff * vx_ff;
         svy_ff <= sy_ff * vy_ff;
         c1_ff  <= sx_ff * vy_ff;
         c2_ff  <= sy_ff * vx_ff;
         wwx_ff <= wx_ff * wx_ff;
         wwy_ff <= wy_ff * wy_ff;
         vvx_ff <= vx_ff * vx_ff;
         vvy_ff <= vy_ff * vy_ff;
         ssx_ff <= sx_ff * sx_ff;
         ssy_ff <= sy_ff * sy_ff;

         dsw_ff   <= SumW'(swx_ff) + SumW'(swy_ff);
         dsv_ff   <= SumW'(svx_ff) + SumW'(svy_ff);
         cross_ff <= SumW'(c1_ff) - SumW'(c2_ff);
         eb_ff    <= SumW'(wwx_ff) + SumW'(wwy_ff);
         ea_ff    <= SumW'(vvx_ff) + SumW'(vvy_ff);
         nn_ff    <= SumW'(ssx_ff) + SumW'(ssy_ff);
      end
   end

   // angle at b not acute (a-b).(p-b) <= 0, i.e. s.w >= 0: distance to b
   always_comb begin
      perp_in = 1'b0;
      cr_in   = cross_ff[SumW-1] ? SumW'(-cross_ff) : SumW'(cross_ff);
      if (dsw_ff >= 0) begin
         sel_in = eb_ff;
      end else if (dsv_ff <= 0) begin
         sel_in = ea_ff;
      end else begin
         sel_in  = nn_ff;
         perp_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0]       <= spmd_pkg::sqrt_init(spmd_pkg::RadW'({sel_in, 32'b0}));
         car_ff[0].perp <= perp_in;
         car_ff[0].cr   <= cr_in;
      end
   end

   for (genvar i = 1; i <= RootW; i++) begin : g_sqrt
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[i]  <= spmd_pkg::sqrt_step(sq_ff[i-1]);
            car_ff[i] <= car_ff[i-1];
         end
      end
   end

   // endpoint case reuses the divider: root of (len^2 * 2^32) over 2^16
   always_comb begin
      if (car_ff[RootW].perp) begin
         num_in = spmd_pkg::NumW'({car_ff[RootW].cr, 16'b0});
         den_in = sq_ff[RootW].root;
      end else begin
         num_in = spmd_pkg::NumW'(sq_ff[RootW].root);
         den_in = spmd_pkg::UnitDen;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[0] <= spmd_pkg::div_init(num_in, den_in);
      end
   end

   for (genvar i = 1; i <= QuoW; i++) begin : g_div
      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[i] <= spmd_pkg::div_step(dv_ff[i-1]);
         end
      end
   end

   assign out_valid = vld_ff[Lat-1];
   assign distance  = spmd_pkg::div_result(dv_ff[QuoW]);

endmodule
